/* hw/rtl/jpeg_xmp_segment_extractor_top_macros.svh */
// assertion macros for the xmp segment extractor checker
// no dependencies; included by the checker file only
`ifndef JPEG_XMP_SEGMENT_EXTRACTOR_TOP_MACROS_SVH
`define JPEG_XMP_SEGMENT_EXTRACTOR_TOP_MACROS_SVH

// same-cycle implication, masked during reset
`define JXSE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("jxse check failed");

// next-cycle implication, masked during reset
`define JXSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("jxse check failed");

// next-cycle implication, also checked across reset
`define JXSE_ASSERT_NEXT_ANY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("jxse check failed");

`endif

/* hw/rtl/jxse_pkg.sv */
// types and constants of the jpeg xmp segment extractor
// no dependencies; used by every module of the block
package jxse_pkg;

    localparam int unsigned SIG_LEN   = 28;
    localparam int unsigned SIG_TOTAL = 29;

    localparam logic [7:0] MARK_FILL = 8'hFF;
    localparam logic [7:0] MARK_SOI  = 8'hD8;
    localparam logic [7:0] MARK_EOI  = 8'hD9;
    localparam logic [7:0] MARK_SOS  = 8'hDA;
    localparam logic [7:0] MARK_APP1 = 8'hE1;
    localparam logic [7:0] MARK_RST0 = 8'hD0;
    localparam logic [7:0] MARK_RST7 = 8'hD7;
    localparam logic [7:0] MARK_TEM  = 8'h01;

    // result status codes
    typedef enum logic [1:0] {
        ST_MORE      = 2'd0,
        ST_COMPLETE  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_TRUNCATED = 2'd3
    } t_status;

    // parser phase, one-hot
    typedef enum logic [9:0] {
        PH_SOI0 = 10'b00_0000_0001,
        PH_SOI1 = 10'b00_0000_0010,
        PH_MARK = 10'b00_0000_0100,
        PH_CODE = 10'b00_0000_1000,
        PH_LENH = 10'b00_0001_0000,
        PH_LENL = 10'b00_0010_0000,
        PH_SKIP = 10'b00_0100_0000,
        PH_SIG  = 10'b00_1000_0000,
        PH_PAY  = 10'b01_0000_0000,
        PH_DONE = 10'b10_0000_0000
    } t_phase;

    // one result item handed from the parser to the output stage
    typedef struct packed {
        logic [7:0] packet_byte;
        logic       byte_valid;
        logic       final_res;
        t_status    status;
    } t_result;

    // namespace text, one character per index
    function automatic logic [7:0] ns_char(input logic [4:0] idx);
        logic [7:0] c;
        unique case (idx)
            5'd0:  c = 8'h68;
            5'd1:  c = 8'h74;
            5'd2:  c = 8'h74;
            5'd3:  c = 8'h70;
            5'd4:  c = 8'h3A;
            5'd5:  c = 8'h2F;
            5'd6:  c = 8'h2F;
            5'd7:  c = 8'h6E;
            5'd8:  c = 8'h73;
            5'd9:  c = 8'h2E;
            5'd10: c = 8'h61;
            5'd11: c = 8'h64;
            5'd12: c = 8'h6F;
            5'd13: c = 8'h62;
            5'd14: c = 8'h65;
            5'd15: c = 8'h2E;
            5'd16: c = 8'h63;
            5'd17: c = 8'h6F;
            5'd18: c = 8'h6D;
            5'd19: c = 8'h2F;
            5'd20: c = 8'h78;
            5'd21: c = 8'h61;
            5'd22: c = 8'h70;
            5'd23: c = 8'h2F;
            5'd24: c = 8'h31;
            5'd25: c = 8'h2E;
            5'd26: c = 8'h30;
            5'd27: c = 8'h2F;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/jpeg_xmp_segment_extractor_top.sv */
// top level of the jpeg xmp segment extractor
// depends on jxse_pkg, jxse_parser, jxse_out_stage
//
// channel   dir  tdata          tuser                      tlast
// s_axis    in   file_byte[7:0] -                          end_of_file
// m_axis    out  packet_byte    byte_valid, status[1:0]    final_res
//
// one file byte is taken per cycle while the output register has room; its result, if any, shows in the next cycle
// the phase machine and segment counters update in the accepting cycle
// a stalled result holds in the output register; input keeps flowing while
// that register is empty or drains in the same cycle
// synchronous reset returns the walker to waiting for the first soi byte
module jpeg_xmp_segment_extractor_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] file_byte
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] packet_byte
    output logic [2:0] o_m_tuser,   // [0] byte_valid, [2:1] status
    output logic       o_m_tlast
);
    import jxse_pkg::*;

    logic    s_accept;
    logic    res_v;
    t_result res;
    t_result out_res;
    logic    room;

    assign o_s_tready = room;
    assign s_accept   = i_s_tvalid && room;

    // segment walker
    jxse_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (s_accept),
        .i_file_byte   (i_s_tdata),
        .i_end_of_file (i_s_tlast),
        .o_res_v       (res_v),
        .o_res         (res)
    );

    // output register
    jxse_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (s_accept && res_v),
        .i_res      (res),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_res      (out_res),
        .o_room     (room)
    );

    assign o_m_tdata = out_res.packet_byte;
    assign o_m_tuser = {out_res.status, out_res.byte_valid};
    assign o_m_tlast = out_res.final_res;

endmodule

/* hw/rtl/jxse_parser.sv */
// marker segment walker: phase register, counters and per-byte result logic
// depends on jxse_pkg
module jxse_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_file_byte,
    input  logic             i_end_of_file,
    output logic             o_res_v,
    output jxse_pkg::t_result o_res
);
    import jxse_pkg::*;

    t_phase      r_phase,   n_phase;
    logic [15:0] r_remain,  n_remain;
    logic [7:0]  r_len_hi,  n_len_hi;
    logic [4:0]  r_sig_idx, n_sig_idx;
    logic        r_sig_ok,  n_sig_ok;
    logic        r_is_app1, n_is_app1;

    logic [15:0] seg_len;
    logic [15:0] remain_dec;
    logic        res_v;
    t_result     res;

    assign seg_len    = {r_len_hi, i_file_byte};
    assign remain_dec = r_remain - 16'd1;

    // one step of the segment walk
    always_comb begin
        n_phase   = r_phase;
        n_remain  = r_remain;
        n_len_hi  = r_len_hi;
        n_sig_idx = r_sig_idx;
        n_sig_ok  = r_sig_ok;
        n_is_app1 = r_is_app1;
        res_v     = 1'b0;
        res       = '{packet_byte: 8'h00, byte_valid: 1'b0, final_res: 1'b1,
                      status: ST_NOT_FOUND};

        unique case (r_phase)
            PH_SOI0: begin
                if (i_file_byte == MARK_FILL) n_phase = PH_SOI1;
                else begin
                    n_phase = PH_DONE;
                    res_v   = 1'b1;
                end
            end
            PH_SOI1: begin
                if (i_file_byte == MARK_SOI) n_phase = PH_MARK;
                else begin
                    n_phase = PH_DONE;
                    res_v   = 1'b1;
                end
            end
            PH_MARK: begin
                if (i_file_byte == MARK_FILL) n_phase = PH_CODE;
                else begin
                    n_phase = PH_DONE;
                    res_v   = 1'b1;
                end
            end
            PH_CODE: begin
                priority if (i_file_byte == MARK_FILL) begin
                    n_phase = PH_CODE;
                end else if (i_file_byte == MARK_TEM
                             || (i_file_byte >= MARK_RST0 && i_file_byte <= MARK_EOI)) begin
                    n_phase = PH_MARK;
                end else if (i_file_byte == MARK_SOS) begin
                    n_phase = PH_DONE;
                    res_v   = 1'b1;
                end else begin
                    n_is_app1 = (i_file_byte == MARK_APP1);
                    n_phase   = PH_LENH;
                end
            end
            PH_LENH: begin
                n_len_hi = i_file_byte;
                n_phase  = PH_LENL;
            end
            PH_LENL: begin
                if (seg_len < 16'd2) begin
                    n_phase = PH_DONE;
                    res_v   = 1'b1;
                end else begin
                    n_remain = seg_len - 16'd2;
                    priority if (seg_len == 16'd2) begin
                        n_phase = PH_MARK;
                    end else if (r_is_app1 && (seg_len - 16'd2) > 16'(SIG_TOTAL)) begin
                        n_sig_idx = '0;
                        n_sig_ok  = 1'b1;
                        n_phase   = PH_SIG;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                n_remain = remain_dec;
                if (remain_dec == 16'd0) n_phase = PH_MARK;
            end
            PH_SIG: begin
                // compare the namespace text, then drop its terminator
                if (r_sig_idx < 5'(SIG_LEN)) begin
                    if (i_file_byte != ns_char(r_sig_idx)) n_sig_ok = 1'b0;
                    n_sig_idx = r_sig_idx + 5'd1;
                end else begin
                    n_phase = r_sig_ok ? PH_PAY : PH_SKIP;
                end
                n_remain = remain_dec;
            end
            PH_PAY: begin
                n_remain        = remain_dec;
                res_v           = 1'b1;
                res.packet_byte = i_file_byte;
                res.byte_valid  = 1'b1;
                if (remain_dec == 16'd0) begin
                    n_phase       = PH_DONE;
                    res.final_res = 1'b1;
                    res.status    = ST_COMPLETE;
                end else begin
                    res.final_res = 1'b0;
                    res.status    = ST_MORE;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        // last byte of the file closes the output and rearms the walker
        if (i_end_of_file) begin
            if (!res_v && n_phase != PH_DONE) begin
                res_v = 1'b1;
                res   = '{packet_byte: 8'h00, byte_valid: 1'b0, final_res: 1'b1,
                          status: ST_NOT_FOUND};
            end else if (res_v && !res.final_res) begin
                res = '{packet_byte: 8'h00, byte_valid: 1'b0, final_res: 1'b1,
                        status: ST_TRUNCATED};
            end
            n_phase   = PH_SOI0;
            n_remain  = '0;
            n_len_hi  = '0;
            n_sig_idx = '0;
            n_sig_ok  = 1'b1;
            n_is_app1 = 1'b0;
        end
    end

    // walker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SOI0;
            r_remain  <= '0;
            r_len_hi  <= '0;
            r_sig_idx <= '0;
            r_sig_ok  <= 1'b1;
            r_is_app1 <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_remain  <= n_remain;
            r_len_hi  <= n_len_hi;
            r_sig_idx <= n_sig_idx;
            r_sig_ok  <= n_sig_ok;
            r_is_app1 <= n_is_app1;
        end
    end

    assign o_res_v = res_v;
    assign o_res   = res;

endmodule

/* hw/rtl/jxse_out_stage.sv */
// result register toward the output stream, with ready back to the input
// depends on jxse_pkg
module jxse_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  jxse_pkg::t_result i_res,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output jxse_pkg::t_result o_res,
    output logic              o_room
);
    import jxse_pkg::*;

    logic    r_valid;
    t_result r_res;

    // free when empty or when the held result leaves this cycle
    assign o_room = !r_valid || i_m_tready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_load;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_room && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_res      = r_res;

endmodule

/* hw/rtl/jxse_checker.sv */
// port-level checks of the jpeg xmp segment extractor
// depends on jxse_pkg and jpeg_xmp_segment_extractor_top_macros.svh; bound to the top level
`include "jpeg_xmp_segment_extractor_top_macros.svh"

module jxse_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic [2:0] o_m_tuser,
    input logic       o_m_tlast
);
    import jxse_pkg::*;

    logic [11:0] out_bits;

    // every result field seen at the port
    assign out_bits = {o_m_tlast, o_m_tuser, o_m_tdata};

    // a stalled result holds its payload
    `JXSE_ASSERT_NEXT(a_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(out_bits))

    // nothing is taken in while the output is full and stalled
    `JXSE_ASSERT_NOW(a_backpressure, o_m_tvalid && !i_m_tready, !o_s_tready)

    // last flag goes with every status but more-follows
    `JXSE_ASSERT_NOW(a_last_status, o_m_tvalid, o_m_tlast == (o_m_tuser[2:1] != ST_MORE))

    // a result without a payload byte carries zero data and is final
    `JXSE_ASSERT_NOW(a_empty_final, o_m_tvalid && !o_m_tuser[0], o_m_tdata == 8'h00 && o_m_tlast)

    // reset empties the output register
    `JXSE_ASSERT_NEXT_ANY(a_reset, !i_rst_n, !o_m_tvalid)

endmodule

bind jpeg_xmp_segment_extractor_top jxse_checker u_jxse_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

/* tb/sv/jpeg_xmp_segment_extractor_top_test.sv */
`timescale 1ns / 100ps
// self-checking testbench of jpeg_xmp_segment_extractor_top
// depends on jxse_pkg and the top level; streams whole jpeg files and checks each
// result against a byte walker kept inside the bench
module jpeg_xmp_segment_extractor_top_test;
    import jxse_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES = 16;

    // xmp namespace text, first character in the top byte
    localparam logic [8*SIG_LEN-1:0] NS_TEXT = {
        8'h68, 8'h74, 8'h74, 8'h70, 8'h3A, 8'h2F, 8'h2F, 8'h6E, 8'h73, 8'h2E,
        8'h61, 8'h64, 8'h6F, 8'h62, 8'h65, 8'h2E, 8'h63, 8'h6F, 8'h6D, 8'h2F,
        8'h78, 8'h61, 8'h70, 8'h2F, 8'h31, 8'h2E, 8'h30, 8'h2F
    };

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;

    // idling and hold-off controls
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_ticket    = 0;
    int unsigned hold_seen      = 0;
    int unsigned hold_left      = 0;

    int unsigned cycle_cnt = 0;
    int unsigned bytes_fed = 0;
    int unsigned fail_cnt  = 0;

    logic [7:0] jpeg_file_q[$];
    t_result    xmp_out_q[$];

    // byte walker state
    t_phase      w_phase;
    logic [15:0] w_left;
    logic [7:0]  w_len_hi;
    logic [4:0]  w_sig_idx;
    logic        w_sig_ok;
    logic        w_app1;
    logic        w_done;

    jpeg_xmp_segment_extractor_top i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),    // [7:0] file_byte
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),    // [7:0] packet_byte
        .o_m_tuser  (m_tuser),    // [0] byte_valid, [2:1] status
        .o_m_tlast  (m_tlast)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // byte walker
    // ------------------------------------------------------------------

    function automatic t_result mk_res(input logic [7:0] b, input logic v, input logic f,
                                       input t_status s);
        t_result r;
        r.packet_byte = b;
        r.byte_valid  = v;
        r.final_res   = f;
        r.status      = s;
        return r;
    endfunction

    function automatic void rearm_walker();
        w_phase   = PH_SOI0;
        w_left    = 16'd0;
        w_len_hi  = 8'd0;
        w_sig_idx = 5'd0;
        w_sig_ok  = 1'b1;
        w_app1    = 1'b0;
        w_done    = 1'b0;
    endfunction

    // search over without a packet
    function automatic bit end_search(output t_result r);
        w_phase = PH_DONE;
        w_done  = 1'b1;
        r = mk_res(8'h00, 1'b0, 1'b1, ST_NOT_FOUND);
        return 1'b1;
    endfunction

    // advance the walker by one file byte; returns 1 when a result is due
    function automatic bit walk_jpeg_byte(input logic [7:0] b, input logic eof,
                                          output t_result r);
        bit          got;
        logic [15:0] seg_len;
        got = 1'b0;
        r   = mk_res(8'h00, 1'b0, 1'b0, ST_MORE);
        if (!w_done) begin
            case (w_phase)
                PH_SOI0: begin
                    if (b == MARK_FILL) w_phase = PH_SOI1;
                    else got = end_search(r);
                end
                PH_SOI1: begin
                    if (b == MARK_SOI) w_phase = PH_MARK;
                    else got = end_search(r);
                end
                PH_MARK: begin
                    if (b == MARK_FILL) w_phase = PH_CODE;
                    else got = end_search(r);
                end
                PH_CODE: begin
                    // fill bytes keep us here; standalone markers carry no length
                    if (b == MARK_FILL) begin
                        w_phase = PH_CODE;
                    end else if (b == MARK_TEM || (b >= MARK_RST0 && b <= MARK_EOI)) begin
                        w_phase = PH_MARK;
                    end else if (b == MARK_SOS) begin
                        got = end_search(r);
                    end else begin
                        w_app1  = (b == MARK_APP1);
                        w_phase = PH_LENH;
                    end
                end
                PH_LENH: begin
                    w_len_hi = b;
                    w_phase  = PH_LENL;
                end
                PH_LENL: begin
                    seg_len = {w_len_hi, b};
                    if (seg_len < 16'd2) begin
                        got = end_search(r);
                    end else begin
                        w_left = seg_len - 16'd2;
                        if (w_left == 16'd0) begin
                            w_phase = PH_MARK;
                        end else if (w_app1 && w_left > SIG_TOTAL) begin
                            w_sig_idx = 5'd0;
                            w_sig_ok  = 1'b1;
                            w_phase   = PH_SIG;
                        end else begin
                            w_phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    w_left = w_left - 16'd1;
                    if (w_left == 16'd0) w_phase = PH_MARK;
                end
                PH_SIG: begin
                    // namespace compare, then one byte that is never compared
                    if (w_sig_idx < SIG_LEN) begin
                        if (b != NS_TEXT[8*(SIG_LEN-1-w_sig_idx) +: 8]) w_sig_ok = 1'b0;
                        w_sig_idx = w_sig_idx + 5'd1;
                    end else begin
                        w_phase = w_sig_ok ? PH_PAY : PH_SKIP;
                    end
                    w_left = w_left - 16'd1;
                end
                PH_PAY: begin
                    w_left = w_left - 16'd1;
                    if (w_left == 16'd0) begin
                        w_phase = PH_DONE;
                        w_done  = 1'b1;
                        r = mk_res(b, 1'b1, 1'b1, ST_COMPLETE);
                    end else begin
                        r = mk_res(b, 1'b1, 1'b0, ST_MORE);
                    end
                    got = 1'b1;
                end
                default: begin
                    w_phase = PH_DONE;
                    w_done  = 1'b1;
                end
            endcase
        end

        // last byte of the file closes the output and rearms
        if (eof) begin
            if (!got && !w_done) begin
                r   = mk_res(8'h00, 1'b0, 1'b1, ST_NOT_FOUND);
                got = 1'b1;
            end else if (got && !r.final_res) begin
                r = mk_res(8'h00, 1'b0, 1'b1, ST_TRUNCATED);
            end
            rearm_walker();
        end
        return got;
    endfunction

    // ------------------------------------------------------------------
    // file builders
    // ------------------------------------------------------------------

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int unsigned rnd_fill();
        return ($urandom_range(99) < 20) ? $urandom_range(1, 3) : 0;
    endfunction

    // mostly short packets, now and then a long one
    function automatic int unsigned rnd_payload_len();
        return ($urandom_range(99) < 4) ? $urandom_range(150, 400) : $urandom_range(1, 40);
    endfunction

    task automatic add_marker(input logic [7:0] code, input int unsigned nfill);
        jpeg_file_q.push_back(MARK_FILL);
        repeat (nfill) jpeg_file_q.push_back(MARK_FILL);
        jpeg_file_q.push_back(code);
    endtask

    task automatic add_segment(input logic [7:0] code, input logic [15:0] seg_len,
                               input int unsigned nfill);
        add_marker(code, nfill);
        jpeg_file_q.push_back(seg_len[15:8]);
        jpeg_file_q.push_back(seg_len[7:0]);
        if (seg_len >= 16'd2) repeat (seg_len - 16'd2) jpeg_file_q.push_back(rnd_byte());
    endtask

    // app1 segment: namespace text up front (one character spoiled when bad_idx >= 0)
    task automatic add_app1(input int unsigned data_len, input int bad_idx,
                            input int unsigned nfill);
        logic [15:0] seg_len;
        logic [7:0]  c;
        seg_len = 16'(data_len + 2);
        add_marker(MARK_APP1, nfill);
        jpeg_file_q.push_back(seg_len[15:8]);
        jpeg_file_q.push_back(seg_len[7:0]);
        for (int unsigned i = 0; i < data_len; i++) begin
            if (i < SIG_LEN) begin
                c = NS_TEXT[8*(SIG_LEN-1-i) +: 8];
                if (bad_idx >= 0 && i == bad_idx) c = c ^ (8'h01 << $urandom_range(0, 7));
                jpeg_file_q.push_back(c);
            end else begin
                jpeg_file_q.push_back(rnd_byte());
            end
        end
    endtask

    task automatic add_random_segment();
        logic [7:0]  code;
        int unsigned k;
        case ($urandom_range(9))
            0, 1: begin
                // standalone marker
                k = $urandom_range(0, 10);
                code = (k == 0) ? MARK_TEM : MARK_RST0 + 8'(k - 1);
                add_marker(code, rnd_fill());
            end
            2: begin
                do code = rnd_byte(); while (code == MARK_TEM || code == MARK_FILL ||
                                             (code >= MARK_RST0 && code <= MARK_SOS));
                add_segment(code, 16'd2, rnd_fill());
            end
            3: add_app1($urandom_range(1, SIG_TOTAL), -1, rnd_fill());
            4: add_app1($urandom_range(SIG_TOTAL + 1, 60), $urandom_range(0, SIG_LEN - 1),
                        rnd_fill());
            5: begin
                // length below two
                add_marker(rnd_byte() | 8'h20, 0);
                jpeg_file_q.push_back(8'h00);
                jpeg_file_q.push_back(8'($urandom_range(0, 1)));
            end
            6: jpeg_file_q.push_back(rnd_byte() & 8'hFE);
            default: begin
                do code = rnd_byte(); while (code == MARK_TEM || code == MARK_FILL ||
                                             (code >= MARK_RST0 && code <= MARK_SOS));
                add_segment(code, 16'(($urandom_range(99) < 3) ? $urandom_range(256, 300)
                                                               : $urandom_range(2, 24)),
                            rnd_fill());
            end
        endcase
    endtask

    task automatic build_random_file();
        int unsigned pick;
        int          bad;
        jpeg_file_q.delete();
        pick = $urandom_range(99);
        if (pick < 10) begin
            // plain noise
            repeat ($urandom_range(1, 10)) jpeg_file_q.push_back(rnd_byte());
        end else begin
            if (pick < 14) jpeg_file_q.push_back(rnd_byte());
            jpeg_file_q.push_back(MARK_FILL);
            jpeg_file_q.push_back(MARK_SOI);
            repeat ($urandom_range(0, 3)) add_random_segment();
            if ($urandom_range(99) < 75) begin
                bad = ($urandom_range(99) < 15) ? int'($urandom_range(0, SIG_LEN - 1)) : -1;
                add_app1(SIG_TOTAL + rnd_payload_len(), bad, rnd_fill());
            end
            case ($urandom_range(3))
                0: begin
                    add_marker(MARK_SOS, 0);
                    repeat ($urandom_range(1, 6)) jpeg_file_q.push_back(rnd_byte());
                end
                1: add_marker(MARK_EOI, 0);
                2: repeat ($urandom_range(1, 4)) jpeg_file_q.push_back(rnd_byte());
                default: ;
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // request driving
    // ------------------------------------------------------------------

    // called and returns at a falling edge; the walker runs after the accept
    task automatic push_byte(input logic [7:0] b, input logic eof);
        int unsigned gap;
        t_result     r;
        gap = 0;
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) gap++;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eof;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        bytes_fed++;
        if (walk_jpeg_byte(b, eof, r)) xmp_out_q.push_back(r);
    endtask

    // send the built file, cut short to keep bytes when keep is nonzero
    task automatic stream_file(input int unsigned keep);
        int unsigned n;
        n = (keep == 0 || keep > jpeg_file_q.size()) ? jpeg_file_q.size() : keep;
        for (int unsigned i = 0; i < n; i++) push_byte(jpeg_file_q[i], i == n - 1);
        jpeg_file_q.delete();
    endtask

    // sender goes quiet until every expected result is out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (xmp_out_q.size() != 0) @(negedge clk);
    endtask

    task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen <= hold_ticket;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge clk) begin : result_check
        t_result want;
        if (rst_n && m_tvalid && m_tready) begin
            if (xmp_out_q.size() == 0) begin
                $display("%0t: result with none expected, actual tdata %h tuser %h tlast %b",
                         $time, m_tdata, m_tuser, m_tlast);
                fail_cnt++;
            end else begin
                want = xmp_out_q.pop_front();
                check_field("packet_byte", want.packet_byte, m_tdata);
                check_field("byte_valid", {7'd0, want.byte_valid}, {7'd0, m_tuser[0]});
                check_field("final_res", {7'd0, want.final_res}, {7'd0, m_tlast});
                check_field("status", {6'd0, want.status}, {6'd0, m_tuser[2:1]});
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout at %0t with %0d results outstanding", $time, xmp_out_q.size());
            $display("FAIL jpeg_xmp_segment_extractor_top");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // wrong or missing soi, and end of file before the search ends
    task automatic test_soi_check();
        jpeg_file_q = '{8'h00};
        stream_file(0);
        jpeg_file_q = '{MARK_FILL, 8'h00};
        stream_file(0);
        jpeg_file_q = '{MARK_FILL};
        stream_file(0);
        jpeg_file_q = '{MARK_FILL, MARK_SOI, MARK_FILL};
        stream_file(0);
    endtask

    // fill bytes, standalone markers, zero-length data, then sos ends the search
    task automatic test_marker_walk();
        jpeg_file_q = '{MARK_FILL, MARK_SOI};
        add_marker(MARK_TEM, 1);
        add_marker(MARK_RST0, 0);
        add_marker(MARK_EOI, 0);
        add_segment(8'hC0, 16'd2, 0);
        add_marker(MARK_SOS, 0);
        jpeg_file_q.push_back(8'hFF);
        stream_file(0);
    endtask

    // non-marker byte where a marker must start, and a length below two
    task automatic test_broken_segments();
        jpeg_file_q = '{MARK_FILL, MARK_SOI};
        add_segment(8'hC4, 16'd3, 0);
        jpeg_file_q.push_back(8'h55);
        jpeg_file_q.push_back(8'h00);
        stream_file(0);
        jpeg_file_q = '{MARK_FILL, MARK_SOI, MARK_FILL, 8'hE0, 8'h00, 8'h01};
        stream_file(0);
    endtask

    // app1 too short for a packet and app1 with a wrong namespace are walked past
    task automatic test_app1_skip();
        jpeg_file_q = '{MARK_FILL, MARK_SOI};
        add_app1(SIG_TOTAL, -1, 0);
        add_app1(SIG_TOTAL + 5, SIG_LEN - 1, 0);
        add_marker(MARK_EOI, 0);
        stream_file(0);
    endtask

    // full packets: one followed by trailing bytes, one ending on the last file byte
    task automatic test_xmp_packet();
        jpeg_file_q = '{MARK_FILL, MARK_SOI};
        add_app1(SIG_TOTAL + 2, -1, 2);
        repeat (3) jpeg_file_q.push_back(rnd_byte());
        stream_file(0);
        jpeg_file_q = '{MARK_FILL, MARK_SOI};
        add_app1(SIG_TOTAL + 1, -1, 0);
        stream_file(0);
    endtask

    // end of file inside the payload
    task automatic test_truncated_packet();
        jpeg_file_q = '{MARK_FILL, MARK_SOI};
        add_app1(SIG_TOTAL + 10, -1, 0);
        stream_file(jpeg_file_q.size() - 5);
    endtask

    // long receiver hold-off while the sender keeps offering a long packet
    task automatic test_output_backpressure();
        set_idling(0, 0);
        hold_ticket <= hold_ticket + 1;
        jpeg_file_q = '{MARK_FILL, MARK_SOI};
        add_app1(SIG_TOTAL + 80, -1, 0);
        stream_file(0);
        wait_drained();
    endtask

    task automatic test_random_files(input int unsigned src_pct, input int unsigned sink_pct,
                                     input int unsigned nbytes);
        int unsigned target;
        target = bytes_fed + nbytes;
        set_idling(src_pct, sink_pct);
        while (bytes_fed < target) begin
            build_random_file();
            stream_file(($urandom_range(99) < 15) ? $urandom_range(1, jpeg_file_q.size()) : 0);
        end
        wait_drained();
    endtask

    initial begin
        rearm_walker();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_idling(0, 0);
        test_soi_check();
        test_marker_walk();
        test_broken_segments();
        test_app1_skip();
        test_xmp_packet();
        test_truncated_packet();
        wait_drained();

        test_output_backpressure();

        test_random_files(0, 0, 365);
        test_random_files(61, 0, 365);
        test_random_files(0, 61, 365);
        test_random_files(6, 6, 365);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_cnt == 0) begin
            $display("PASS jpeg_xmp_segment_extractor_top");
        end else begin
            $display("FAIL jpeg_xmp_segment_extractor_top");
        end
        $finish;
    end

endmodule
